### hw/rtl/dmwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmwc_pkg;

  localparam int ADDR_W                 = 64;
  localparam int WORD_W                 = 32;
  localparam int OUT_W                  = 48;
  localparam int WORD_SHIFT             = 2;
  localparam int INSTR_INDEX_BITS_DEF   = 14;
  localparam int DATA_INDEX_BITS_DEF    = 13;
  localparam int COUNTER_BITS_DEF       = 48;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_FILL,
    ST_CLEAR,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               side;
    logic [ADDR_W-1:0]  address;
    logic [WORD_W-1:0]  write_word;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [WORD_W-1:0]  read_word;
    logic [OUT_W-1:0]   hit_total;
    logic [OUT_W-1:0]   miss_total;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic lookup_done;
    logic fill_wr;
    logic sweep_wr;
    logic cnt_clear;
    logic report;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/dmwc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dmwc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire dmwc_pkg::cmd_e cmd_i,
  input  wire dmwc_pkg::stat_t stat_i,
  output logic                busy_o,
  output dmwc_pkg::ctrl_t     ctrl_o
);

  import dmwc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        ctrl_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          unique case (cmd_i)
            CMD_LOOKUP: state_d = ST_READ;
            CMD_FILL:   state_d = ST_FILL;
            CMD_INVAL:  state_d = ST_SWEEP;
            CMD_CLEAR:  state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = ST_COMPARE;
      end
      ST_COMPARE: begin
        ctrl_o.lookup_done = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_FILL: begin
        ctrl_o.fill_wr = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_CLEAR: begin
        ctrl_o.cnt_clear = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_SWEEP: begin
        ctrl_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          ctrl_o.report = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dmwc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dmwc_datapath #(
  parameter int INSTR_INDEX_BITS = dmwc_pkg::INSTR_INDEX_BITS_DEF,
  parameter int DATA_INDEX_BITS  = dmwc_pkg::DATA_INDEX_BITS_DEF,
  parameter int COUNTER_BITS     = dmwc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dmwc_pkg::req_t  req_i,
  input  wire dmwc_pkg::ctrl_t ctrl_i,
  output dmwc_pkg::stat_t      stat_o,
  output logic                 rsp_valid_o,
  output dmwc_pkg::rsp_t       rsp_o
);

  import dmwc_pkg::*;

  localparam int IT_W  = ADDR_W - WORD_SHIFT - INSTR_INDEX_BITS;
  localparam int DT_W  = ADDR_W - WORD_SHIFT - DATA_INDEX_BITS;
  localparam int IE_W  = 1 + IT_W + WORD_W;
  localparam int DE_W  = 1 + DT_W + WORD_W;
  localparam int SWP_W = (INSTR_INDEX_BITS > DATA_INDEX_BITS) ?
                         INSTR_INDEX_BITS : DATA_INDEX_BITS;

  req_t                           req_q;
  rsp_t                           rsp_q, rsp_d;
  logic                           rsp_valid_q;
  logic [SWP_W-1:0]               sweep_q;
  logic [1:0][COUNTER_BITS-1:0]   hits_q, hits_d;
  logic [1:0][COUNTER_BITS-1:0]   misses_q, misses_d;

  logic [INSTR_INDEX_BITS-1:0]    i_idx, i_addr;
  logic [DATA_INDEX_BITS-1:0]     d_idx, d_addr;
  logic [IT_W-1:0]                i_tag;
  logic [DT_W-1:0]                d_tag;
  logic [IE_W-1:0]                i_rdata, i_wdata;
  logic [DE_W-1:0]                d_rdata, d_wdata;
  logic                           i_en, d_en, i_hit, d_hit, sel_hit, emit;
  logic [WORD_W-1:0]              sel_word;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
    sat_inc = (&c) ? c : c + COUNTER_BITS'(1);
  endfunction

  // request latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_q <= req_i;
    end
  end

  assign i_idx = req_q.address[WORD_SHIFT +: INSTR_INDEX_BITS];
  assign d_idx = req_q.address[WORD_SHIFT +: DATA_INDEX_BITS];
  assign i_tag = req_q.address[ADDR_W-1 -: IT_W];
  assign d_tag = req_q.address[ADDR_W-1 -: DT_W];

  // sweep index wraps to zero after the last entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctrl_i.sweep_wr) begin
      sweep_q <= sweep_q + SWP_W'(1);
    end
  end

  assign stat_o.sweep_last = &sweep_q;

  // memory ports: sweep writes an invalid entry to both sides
  assign i_addr  = ctrl_i.sweep_wr ? sweep_q[INSTR_INDEX_BITS-1:0] : i_idx;
  assign d_addr  = ctrl_i.sweep_wr ? sweep_q[DATA_INDEX_BITS-1:0] : d_idx;
  assign i_wdata = ctrl_i.sweep_wr ? '0 : {1'b1, i_tag, req_q.write_word};
  assign d_wdata = ctrl_i.sweep_wr ? '0 : {1'b1, d_tag, req_q.write_word};
  assign i_en    = ctrl_i.sweep_wr | ((ctrl_i.rd_en | ctrl_i.fill_wr) & !req_q.side);
  assign d_en    = ctrl_i.sweep_wr | ((ctrl_i.rd_en | ctrl_i.fill_wr) & req_q.side);

  dmwc_ram #(
    .WIDTH (IE_W),
    .DEPTH (1 << INSTR_INDEX_BITS)
  ) u_iram (
    .clk_i   (clk_i),
    .en_i    (i_en),
    .we_i    (ctrl_i.sweep_wr | ctrl_i.fill_wr),
    .addr_i  (i_addr),
    .wdata_i (i_wdata),
    .rdata_o (i_rdata)
  );

  dmwc_ram #(
    .WIDTH (DE_W),
    .DEPTH (1 << DATA_INDEX_BITS)
  ) u_dram (
    .clk_i   (clk_i),
    .en_i    (d_en),
    .we_i    (ctrl_i.sweep_wr | ctrl_i.fill_wr),
    .addr_i  (d_addr),
    .wdata_i (d_wdata),
    .rdata_o (d_rdata)
  );

  // tag compare
  assign i_hit    = i_rdata[IE_W-1] && (i_rdata[IE_W-2 -: IT_W] == i_tag);
  assign d_hit    = d_rdata[DE_W-1] && (d_rdata[DE_W-2 -: DT_W] == d_tag);
  assign sel_hit  = req_q.side ? d_hit : i_hit;
  assign sel_word = req_q.side ? d_rdata[WORD_W-1:0] : i_rdata[WORD_W-1:0];

  // statistics
  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (ctrl_i.cnt_clear) begin
      hits_d   = '0;
      misses_d = '0;
    end else if (ctrl_i.lookup_done) begin
      if (sel_hit) begin
        hits_d[req_q.side] = sat_inc(hits_q[req_q.side]);
      end else begin
        misses_d[req_q.side] = sat_inc(misses_q[req_q.side]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
    end
  end

  // result beat
  assign emit = ctrl_i.lookup_done | ctrl_i.fill_wr | ctrl_i.cnt_clear | ctrl_i.report;

  always_comb begin
    rsp_d.hit        = ctrl_i.lookup_done & sel_hit;
    rsp_d.read_word  = rsp_d.hit ? sel_word : '0;
    rsp_d.hit_total  = OUT_W'(hits_d[req_q.side]);
    rsp_d.miss_total = OUT_W'(misses_d[req_q.side]);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= emit;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

### hw/rtl/direct_mapped_word_cache_pair_core.sv
// lookup: read in ST_READ, compare in ST_COMPARE, result registered; busy until idle
// fill and clear-statistics: ST_FILL or ST_CLEAR, result registered; busy until idle
// invalidate-all: one entry per cycle through the entry rams, then a result beat
// the single-port entry ram with registered read is why lookup has its own read state
// reset: busy while the entries are swept invalid
// results carry no backpressure: each beat shows for exactly one cycle on rsp_valid_o
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_word_cache_pair_core #(
  parameter int INSTR_INDEX_BITS = dmwc_pkg::INSTR_INDEX_BITS_DEF,
  parameter int DATA_INDEX_BITS  = dmwc_pkg::DATA_INDEX_BITS_DEF,
  parameter int COUNTER_BITS     = dmwc_pkg::COUNTER_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // command side: a beat is taken when start_i is high and busy_o is low
  input  wire logic           start_i,
  input  wire dmwc_pkg::req_t req_i,
  output logic                busy_o,
  // result side: one beat per command, one cycle wide
  output logic                rsp_valid_o,
  output dmwc_pkg::rsp_t      rsp_o
);

  import dmwc_pkg::*;

  ctrl_t ctrl;   // sequencing strobes from the controller
  stat_t stat;   // sweep progress back from the datapath

  // controller: sequences lookup (read then compare), fill, counter clear
  // and the invalidate sweep, and holds off commands while working
  dmwc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (req_i.cmd),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  // datapath: request latch, one entry ram per side holding valid, tag and
  // word, tag compare, saturating statistics and the result register
  dmwc_datapath #(
    .INSTR_INDEX_BITS (INSTR_INDEX_BITS),
    .DATA_INDEX_BITS  (DATA_INDEX_BITS),
    .COUNTER_BITS     (COUNTER_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
